@@ hw/rtl/pidcd_pkg.sv @@
// ----------------------------------------------------------------------------
// pidcd_pkg: shared types and constants of the clamped deadband pid controller
// Field widths, register indexes and the configuration record.
// ----------------------------------------------------------------------------
`default_nettype none

package pidcd_pkg;

	// field widths
	localparam int ERR_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int DB_W    = 15;
	localparam int INT_W   = 24;
	localparam int DRV_W   = 16;
	localparam int CFG_W   = 24;
	localparam int IDX_W   = 3;

	// gains are signed fixed point with this many fraction bits
	localparam int GAIN_FRAC_BITS = 8;

	// second difference spans four times the sample range
	localparam int DIFF_W = ERR_W + 2;
	// widest product plus one bit of growth for the three-term sum
	localparam int SUM_W  = GAIN_W + INT_W + 1;

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_GAIN_P         = 3'd0,
		REG_GAIN_I         = 3'd1,
		REG_GAIN_D         = 3'd2,
		REG_DEADBAND       = 3'd3,
		REG_INTEGRAL_UPPER = 3'd4,
		REG_INTEGRAL_LOWER = 3'd5,
		REG_DRIVE_UPPER    = 3'd6,
		REG_DRIVE_LOWER    = 3'd7
	} reg_idx_t;

	// reset values of the limits
	localparam logic signed [INT_W-1:0] INT_UPPER_RST = {1'b0, {(INT_W-1){1'b1}}};
	localparam logic signed [INT_W-1:0] INT_LOWER_RST = {1'b1, {(INT_W-1){1'b0}}};
	localparam logic signed [DRV_W-1:0] DRV_UPPER_RST = {1'b0, {(DRV_W-1){1'b1}}};
	localparam logic signed [DRV_W-1:0] DRV_LOWER_RST = {1'b1, {(DRV_W-1){1'b0}}};

	// configuration record handed to the datapath
	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic        [DB_W-1:0]   deadband;
		logic signed [INT_W-1:0]  integral_upper;
		logic signed [INT_W-1:0]  integral_lower;
		logic signed [DRV_W-1:0]  drive_upper;
		logic signed [DRV_W-1:0]  drive_lower;
	} cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/pidcd_err_if.sv @@
// ----------------------------------------------------------------------------
// pidcd_err_if: error sample channel
// Valid/ready channel carrying one signed error sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidcd_err_if;
	logic                               valid;
	logic                               ready;
	logic signed [pidcd_pkg::ERR_W-1:0] error_sample;

	modport source (output valid, output error_sample, input ready);
	modport sink   (input valid, input error_sample, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pidcd_drv_if.sv @@
// ----------------------------------------------------------------------------
// pidcd_drv_if: drive result channel
// Valid/ready channel carrying one clamped drive value per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidcd_drv_if;
	logic                               valid;
	logic                               ready;
	logic signed [pidcd_pkg::DRV_W-1:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pidcd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// pidcd_cfg_regs: configuration register file
// Write-only gains, deadband and clamp limits, truncated to register width.
// ----------------------------------------------------------------------------
`default_nettype none

module pidcd_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [pidcd_pkg::IDX_W-1:0]       cfg_index,
	input  wire logic [pidcd_pkg::CFG_W-1:0]       cfg_data,
	output pidcd_pkg::cfg_t                        cfg
);

	pidcd_pkg::cfg_t cfg_q;

	// register writes, each takes the low bits of the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= '0;
			cfg_q.gain_i         <= '0;
			cfg_q.gain_d         <= '0;
			cfg_q.deadband       <= '0;
			cfg_q.integral_upper <= pidcd_pkg::INT_UPPER_RST;
			cfg_q.integral_lower <= pidcd_pkg::INT_LOWER_RST;
			cfg_q.drive_upper    <= pidcd_pkg::DRV_UPPER_RST;
			cfg_q.drive_lower    <= pidcd_pkg::DRV_LOWER_RST;
		end else if (cfg_we) begin
			case (pidcd_pkg::reg_idx_t'(cfg_index))
				pidcd_pkg::REG_GAIN_P: begin
					cfg_q.gain_p <= cfg_data[pidcd_pkg::GAIN_W-1:0];
				end
				pidcd_pkg::REG_GAIN_I: begin
					cfg_q.gain_i <= cfg_data[pidcd_pkg::GAIN_W-1:0];
				end
				pidcd_pkg::REG_GAIN_D: begin
					cfg_q.gain_d <= cfg_data[pidcd_pkg::GAIN_W-1:0];
				end
				pidcd_pkg::REG_DEADBAND: begin
					cfg_q.deadband <= cfg_data[pidcd_pkg::DB_W-1:0];
				end
				pidcd_pkg::REG_INTEGRAL_UPPER: begin
					cfg_q.integral_upper <= cfg_data[pidcd_pkg::INT_W-1:0];
				end
				pidcd_pkg::REG_INTEGRAL_LOWER: begin
					cfg_q.integral_lower <= cfg_data[pidcd_pkg::INT_W-1:0];
				end
				pidcd_pkg::REG_DRIVE_UPPER: begin
					cfg_q.drive_upper <= cfg_data[pidcd_pkg::DRV_W-1:0];
				end
				pidcd_pkg::REG_DRIVE_LOWER: begin
					cfg_q.drive_lower <= cfg_data[pidcd_pkg::DRV_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/pidcd_core.sv @@
// ----------------------------------------------------------------------------
// pidcd_core: controller datapath
// Input register, integral update with deadband and clamp, three products,
// floor shift and drive clamp into a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pidcd_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pidcd_pkg::cfg_t  cfg,
	pidcd_err_if.sink             sample,
	pidcd_drv_if.source           result
);

	localparam int ERR_W  = pidcd_pkg::ERR_W;
	localparam int INT_W  = pidcd_pkg::INT_W;
	localparam int DRV_W  = pidcd_pkg::DRV_W;
	localparam int GAIN_W = pidcd_pkg::GAIN_W;
	localparam int DIFF_W = pidcd_pkg::DIFF_W;
	localparam int SUM_W  = pidcd_pkg::SUM_W;
	localparam int P_W    = GAIN_W + ERR_W;
	localparam int I_W    = GAIN_W + INT_W;
	localparam int D_W    = GAIN_W + DIFF_W;

	logic                     valid_s1;
	logic signed [ERR_W-1:0]  err_s1;
	logic                     out_valid_q;
	logic signed [DRV_W-1:0]  drive_q;
	logic signed [INT_W-1:0]  integral_q;
	logic signed [ERR_W-1:0]  prev_q;
	logic signed [ERR_W-1:0]  older_q;

	logic                     advance;
	logic                     take;

	logic signed [ERR_W:0]    err_x;
	logic signed [ERR_W:0]    db_x;
	logic                     in_deadband;
	logic signed [INT_W:0]    acc_sum;
	logic signed [INT_W:0]    acc_hi;
	logic signed [INT_W:0]    acc_lo;
	logic signed [INT_W-1:0]  integral_next;

	logic signed [DIFF_W-1:0] diff;
	logic signed [P_W-1:0]    p_term;
	logic signed [I_W-1:0]    i_term;
	logic signed [D_W-1:0]    d_term;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  shifted;
	logic signed [SUM_W-1:0]  drv_hi;
	logic signed [SUM_W-1:0]  drv_lo;
	logic signed [DRV_W-1:0]  drive_next;

	// handshake: result register frees the input stage
	assign advance      = !out_valid_q || result.ready;
	assign take         = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;
	assign result.valid = out_valid_q;
	assign result.drive = drive_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			err_s1 <= sample.error_sample;
		end
	end

	// integral: add, clear inside deadband, upper then lower clamp
	always_comb begin
		err_x         = (ERR_W+1)'(err_s1);
		db_x          = $signed((ERR_W+1)'(cfg.deadband));
		in_deadband   = (err_x > -db_x) && (err_x < db_x);
		acc_sum       = in_deadband ? '0 : ((INT_W+1)'(integral_q) + (INT_W+1)'(err_s1));
		acc_hi        = (acc_sum >= (INT_W+1)'(cfg.integral_upper))
		              ? (INT_W+1)'(cfg.integral_upper) : acc_sum;
		acc_lo        = (acc_hi <= (INT_W+1)'(cfg.integral_lower))
		              ? (INT_W+1)'(cfg.integral_lower) : acc_hi;
		integral_next = acc_lo[INT_W-1:0];
	end

	// three products, floor shift, upper then lower clamp
	always_comb begin
		diff       = DIFF_W'(older_q) + DIFF_W'(err_s1) - (DIFF_W'(prev_q) <<< 1);
		p_term     = P_W'(cfg.gain_p) * P_W'(err_s1);
		i_term     = I_W'(cfg.gain_i) * I_W'(integral_next);
		d_term     = D_W'(cfg.gain_d) * D_W'(diff);
		sum        = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
		shifted    = sum >>> pidcd_pkg::GAIN_FRAC_BITS;
		drv_hi     = (shifted >= SUM_W'(cfg.drive_upper)) ? SUM_W'(cfg.drive_upper) : shifted;
		drv_lo     = (drv_hi <= SUM_W'(cfg.drive_lower)) ? SUM_W'(cfg.drive_lower) : drv_hi;
		drive_next = drv_lo[DRV_W-1:0];
	end

	// result register and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			integral_q  <= '0;
			prev_q      <= '0;
			older_q     <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (take) begin
				integral_q <= integral_next;
				prev_q     <= err_s1;
				older_q    <= prev_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			drive_q <= drive_next;
		end
	end

	// lower drive limit always holds on a loaded result
	a_drive_lower: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (drive_q >= $past(cfg.drive_lower)))
		else $error("drive below lower limit");

	// upper drive limit holds when the limits do not cross
	a_drive_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (cfg.drive_lower <= cfg.drive_upper)) |=>
		(drive_q <= $past(cfg.drive_upper)))
		else $error("drive above upper limit");

	// integral never drops below its lower limit after an update
	a_integral_lower: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (integral_q >= $past(cfg.integral_lower)))
		else $error("integral below lower limit");

	// a stalled item leaves the controller state alone
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> ($stable(integral_q) && $stable(prev_q) && $stable(older_q)))
		else $error("state changed without a transaction");

	// sample history shifts by one on each processed item
	a_history: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> ((older_q == $past(prev_q)) && (prev_q == $past(err_s1))))
		else $error("sample history out of order");

endmodule

`default_nettype wire

@@ hw/rtl/pid_controller_clamped_deadband.sv @@
// ----------------------------------------------------------------------------
// pid_controller_clamped_deadband: clamped positional pid with deadband
// Top level joining the configuration registers and the controller datapath.
// ----------------------------------------------------------------------------
// usage
//   sample: valid/ready sink, one signed 16-bit error_sample per transaction
//   result: valid/ready source, one clamped signed 16-bit drive per transaction
//   cfg_we/cfg_index/cfg_data: write-only registers (gains, deadband, limits),
//     written while no transaction is in flight
// timing
//   one result per sample; the sample passes the input register, then the
//   result register, from which the drive appears on result; throughput is
//   one sample per cycle while result.ready is high: the integral update,
//   three multipliers and both clamps sit in the single step between registers
// reset
//   arst_n clears both stages, the integral and the sample history, and loads
//   zero gains, zero deadband and full-range limits
// stalls
//   while result.ready is low the finished drive holds; one more sample is
//   still taken into the input register, after which sample.ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_clamped_deadband (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	pidcd_err_if.sink                          sample,
	pidcd_drv_if.source                        result,
	input  wire logic                          cfg_we,
	input  wire logic [pidcd_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [pidcd_pkg::CFG_W-1:0]   cfg_data
);

	pidcd_pkg::cfg_t cfg;

	// configuration registers
	pidcd_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// controller datapath
	pidcd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sample (sample),
		.result (result)
	);

endmodule

`default_nettype wire

@@ tb/pid_controller_clamped_deadband_test.sv @@
// ----------------------------------------------------------------------------
// pid_controller_clamped_deadband_test: self-checking bench of the pid block
// Streams error samples through the valid/ready channels under random sender
// gaps and receiver stalls, reprograms gains, deadband and limits between
// phases, and checks every drive against an in-bench fixed point predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_clamped_deadband_test;
	import pidcd_pkg::*;

	localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
	localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
	localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 <<< GAIN_FRAC_BITS);
	localparam logic signed [ERR_W-1:0]  ERR_MAX  = {1'b0, {(ERR_W-1){1'b1}}};
	localparam logic signed [ERR_W-1:0]  ERR_MIN  = {1'b1, {(ERR_W-1){1'b0}}};
	localparam logic        [DB_W-1:0]   DB_MAX   = '1;
	localparam int RANDOM_PHASES = 15;
	localparam int PHASE_ITEMS   = 130;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	// expected drive values, kept in step with the accepted samples
	class drive_scoreboard;
		cfg_t                    cfg;
		logic signed [ERR_W-1:0] last_err;
		logic signed [ERR_W-1:0] older_err;
		logic signed [INT_W-1:0] integ;
		logic signed [DRV_W-1:0] expected_drives[$];
		int                      error_count;

		function new();
			cfg.gain_p         = '0;
			cfg.gain_i         = '0;
			cfg.gain_d         = '0;
			cfg.deadband       = '0;
			cfg.integral_upper = INT_UPPER_RST;
			cfg.integral_lower = INT_LOWER_RST;
			cfg.drive_upper    = DRV_UPPER_RST;
			cfg.drive_lower    = DRV_LOWER_RST;
			last_err    = '0;
			older_err   = '0;
			integ       = '0;
			error_count = 0;
		endfunction

		function void write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
			case (reg_idx_t'(idx))
				REG_GAIN_P:         cfg.gain_p         = data[GAIN_W-1:0];
				REG_GAIN_I:         cfg.gain_i         = data[GAIN_W-1:0];
				REG_GAIN_D:         cfg.gain_d         = data[GAIN_W-1:0];
				REG_DEADBAND:       cfg.deadband       = data[DB_W-1:0];
				REG_INTEGRAL_UPPER: cfg.integral_upper = data[INT_W-1:0];
				REG_INTEGRAL_LOWER: cfg.integral_lower = data[INT_W-1:0];
				REG_DRIVE_UPPER:    cfg.drive_upper    = data[DRV_W-1:0];
				REG_DRIVE_LOWER:    cfg.drive_lower    = data[DRV_W-1:0];
				default: ;
			endcase
		endfunction

		// one controller step at full width, then back to the state widths
		function void take_sample(input logic signed [ERR_W-1:0] e);
			longint ev, db, acc, diff, total, drv;
			longint kp, ki, kd, iup, ilo, dup, dlo, prev, older;
			logic signed [DRV_W-1:0] drv_q;
			ev    = longint'(e);
			db    = longint'(cfg.deadband);
			kp    = longint'(cfg.gain_p);
			ki    = longint'(cfg.gain_i);
			kd    = longint'(cfg.gain_d);
			iup   = longint'(cfg.integral_upper);
			ilo   = longint'(cfg.integral_lower);
			dup   = longint'(cfg.drive_upper);
			dlo   = longint'(cfg.drive_lower);
			prev  = longint'(last_err);
			older = longint'(older_err);

			// integral with deadband clear, upper clamp then lower clamp
			acc = longint'(integ);
			acc = acc + ev;
			if (ev > -db && ev < db)
				acc = 0;
			if (acc >= iup)
				acc = iup;
			if (acc <= ilo)
				acc = ilo;
			integ = acc[INT_W-1:0];

			// three-term sum, floor shift, drive clamps
			diff  = older + ev - 2 * prev;
			total = kp * ev + ki * acc + kd * diff;
			drv   = total >>> GAIN_FRAC_BITS;
			if (drv >= dup)
				drv = dup;
			if (drv <= dlo)
				drv = dlo;
			drv_q = drv[DRV_W-1:0];

			older_err = last_err;
			last_err  = e;
			expected_drives.push_back(drv_q);
		endfunction

		function void check_drive(input logic signed [DRV_W-1:0] actual);
			logic signed [DRV_W-1:0] expected;
			if (expected_drives.size() == 0) begin
				$error("drive: unexpected transaction, expected none, actual %0d", actual);
				error_count++;
				return;
			end
			expected = expected_drives.pop_front();
			if (actual !== expected) begin
				$error("drive mismatch: expected %0d, actual %0d", expected, actual);
				error_count++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	pidcd_err_if sample_ch ();
	pidcd_drv_if result_ch ();

	drive_scoreboard sb = new();

	logic signed [ERR_W-1:0] error_plan[$];

	pid_controller_clamped_deadband u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// observe register writes and both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (sample_ch.valid && sample_ch.ready)
				sb.take_sample(sample_ch.error_sample);
			if (result_ch.valid && result_ch.ready)
				sb.check_drive(result_ch.drive);
		end
	end

	// receiver backpressure, mode chosen at random and changed after each random span
	initial begin
		stall_mode_t mode;
		int          span;
		int          tick;
		tick = 0;
		result_ch.ready = 1'b0;
		forever begin
			mode = stall_mode_t'($urandom_range(3, 0));
			span = $urandom_range(512, 32);
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (mode)
					STALL_NONE:     result_ch.ready <= 1'b1;
					STALL_LIGHT:    result_ch.ready <= ($urandom_range(3, 0) != 0);
					STALL_HEAVY:    result_ch.ready <= ($urandom_range(3, 0) == 0);
					STALL_PERIODIC: result_ch.ready <= ((tick % 11) >= 6);
					default:        result_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	// hard stop
	initial begin
		#1600000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic cfg_t make_cfg(
		input logic signed [GAIN_W-1:0] gp,
		input logic signed [GAIN_W-1:0] gi,
		input logic signed [GAIN_W-1:0] gd,
		input logic        [DB_W-1:0]   db,
		input logic signed [INT_W-1:0]  iu,
		input logic signed [INT_W-1:0]  il,
		input logic signed [DRV_W-1:0]  du,
		input logic signed [DRV_W-1:0]  dl
	);
		cfg_t c;
		c.gain_p         = gp;
		c.gain_i         = gi;
		c.gain_d         = gd;
		c.deadband       = db;
		c.integral_upper = iu;
		c.integral_lower = il;
		c.drive_upper    = du;
		c.drive_lower    = dl;
		return c;
	endfunction

	function automatic logic signed [GAIN_W-1:0] random_gain();
		int v;
		case ($urandom_range(3, 0))
			0: v = $urandom_range(1024, 0) - 512;
			1: begin
				case ($urandom_range(3, 0))
					0: v = int'(GAIN_MAX);
					1: v = int'(GAIN_MIN);
					2: v = 0;
					default: v = int'(GAIN_ONE);
				endcase
			end
			default: v = $urandom;
		endcase
		return v[GAIN_W-1:0];
	endfunction

	function automatic cfg_t random_config();
		cfg_t                    c;
		logic signed [INT_W-1:0] a, b;
		logic signed [DRV_W-1:0] p, q;
		c.gain_p = random_gain();
		c.gain_i = random_gain();
		c.gain_d = random_gain();
		case ($urandom_range(3, 0))
			0: c.deadband = '0;
			1: c.deadband = DB_W'($urandom_range(64, 1));
			2: c.deadband = DB_W'($urandom);
			default: c.deadband = DB_MAX;
		endcase

		// integral limits: full, ordered, crossed or tight
		a = INT_W'($urandom);
		b = INT_W'($urandom);
		case ($urandom_range(3, 0))
			0: begin
				c.integral_upper = INT_UPPER_RST;
				c.integral_lower = INT_LOWER_RST;
			end
			1: begin
				c.integral_upper = (a >= b) ? a : b;
				c.integral_lower = (a >= b) ? b : a;
			end
			2: begin
				c.integral_upper = (a >= b) ? b : a;
				c.integral_lower = (a >= b) ? a : b;
			end
			default: begin
				a = INT_W'($urandom_range(4096, 1));
				c.integral_upper = a;
				c.integral_lower = -a;
			end
		endcase

		// drive limits, same shapes
		p = DRV_W'($urandom);
		q = DRV_W'($urandom);
		case ($urandom_range(3, 0))
			0: begin
				c.drive_upper = DRV_UPPER_RST;
				c.drive_lower = DRV_LOWER_RST;
			end
			1: begin
				c.drive_upper = (p >= q) ? p : q;
				c.drive_lower = (p >= q) ? q : p;
			end
			2: begin
				c.drive_upper = (p >= q) ? q : p;
				c.drive_lower = (p >= q) ? p : q;
			end
			default: begin
				p = DRV_W'($urandom_range(2048, 1));
				c.drive_upper = p;
				c.drive_lower = -p;
			end
		endcase
		return c;
	endfunction

	function automatic logic signed [ERR_W-1:0] random_error(input logic [DB_W-1:0] db);
		int v;
		case ($urandom_range(7, 0))
			3: v = $urandom_range(128, 0) - 64;
			4: begin
				case ($urandom_range(4, 0))
					0: v = int'(ERR_MAX);
					1: v = int'(ERR_MIN);
					2: v = 0;
					3: v = 1;
					default: v = -1;
				endcase
			end
			// on and just inside the deadband edge
			5: begin
				v = int'(db) - $urandom_range(1, 0);
				if ($urandom_range(1, 0) != 0)
					v = -v;
			end
			// biased runs push the integral into its limits
			6: v = $urandom_range(2000, 0);
			7: v = -$urandom_range(2000, 0);
			default: v = $urandom;
		endcase
		return v[ERR_W-1:0];
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	// all eight registers, with junk above the narrow fields
	task automatic apply_config(input cfg_t c);
		write_reg(REG_GAIN_P,         {8'($urandom), c.gain_p});
		write_reg(REG_GAIN_I,         {8'($urandom), c.gain_i});
		write_reg(REG_GAIN_D,         {8'($urandom), c.gain_d});
		write_reg(REG_DEADBAND,       {9'($urandom), c.deadband});
		write_reg(REG_INTEGRAL_UPPER, c.integral_upper);
		write_reg(REG_INTEGRAL_LOWER, c.integral_lower);
		write_reg(REG_DRIVE_UPPER,    {8'($urandom), c.drive_upper});
		write_reg(REG_DRIVE_LOWER,    {8'($urandom), c.drive_lower});
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// push the planned samples in bursts separated by random gaps
	task automatic send_errors();
		int burst_left = 0;
		int gap;
		while (error_plan.size() != 0) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(40, 1);
				gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
				if (gap != 0) begin
					sample_ch.valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			sample_ch.valid        <= 1'b1;
			sample_ch.error_sample <= error_plan.pop_front();
			do @(posedge clk); while (!sample_ch.ready);
			@(negedge clk);
			burst_left--;
		end
		sample_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (sb.expected_drives.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// stimulus
	initial begin
		cfg_t c;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = '0;
		cfg_data               = '0;
		sample_ch.valid        = 1'b0;
		sample_ch.error_sample = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: zero gains, zero deadband, full limits
		error_plan = '{ERR_MAX, ERR_MIN, 16'sd5};
		send_errors();
		wait_drained();

		// unit gains, deadband edges and full-scale steps
		apply_config(make_cfg(GAIN_ONE, GAIN_ONE, GAIN_ONE, 15'd100,
			INT_UPPER_RST, INT_LOWER_RST, DRV_UPPER_RST, DRV_LOWER_RST));
		error_plan = '{16'sd0, 16'sd99, -16'sd99, 16'sd100, -16'sd100, 16'sd101,
			ERR_MAX, ERR_MAX, ERR_MIN, ERR_MIN};
		send_errors();
		wait_drained();

		// extreme gains and maximum deadband, drive saturates both ways
		apply_config(make_cfg(GAIN_MAX, GAIN_MIN, GAIN_MAX, DB_MAX,
			INT_UPPER_RST, INT_LOWER_RST, DRV_UPPER_RST, DRV_LOWER_RST));
		error_plan = '{ERR_MAX, ERR_MIN, -16'sd32767, 16'sd32766};
		send_errors();
		wait_drained();

		// crossed limits, lower bound wins
		apply_config(make_cfg(GAIN_ONE, GAIN_ONE, GAIN_ONE, 15'd0,
			-24'sd1000, 24'sd1000, -16'sd5, 16'sd5));
		error_plan = '{16'sd200, -16'sd200, 16'sd0};
		send_errors();
		wait_drained();

		// tiny gain, negative sums round toward minus infinity
		apply_config(make_cfg(16'sd1, 16'sd0, 16'sd0, 15'd0,
			INT_UPPER_RST, INT_LOWER_RST, DRV_UPPER_RST, DRV_LOWER_RST));
		error_plan = '{-16'sd1, -16'sd255, -16'sd256, -16'sd257, 16'sd255};
		send_errors();
		wait_drained();

		// random settings and samples
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			c = random_config();
			apply_config(c);
			for (int n = 0; n < PHASE_ITEMS; n++)
				error_plan.push_back(random_error(c.deadband));
			send_errors();
			wait_drained();
		end

		repeat (8) @(negedge clk);
		if (sb.error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
